// File: rtl/xpath_token_lexer_core_macros.svh
// Assertion macros for the checker file.
`ifndef XPATH_TOKEN_LEXER_CORE_MACROS_SVH
`define XPATH_TOKEN_LEXER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define XTL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xtl same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define XTL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xtl next-cycle check failed");

`endif

// File: rtl/xtl_pkg.sv
`default_nettype none

package xtl_pkg;

  // Result field widths
  localparam int POS_W  = 16;
  localparam int KIND_W = 5;

  // Token queue geometry
  localparam int TQ_DEPTH = 4;
  localparam int TQ_AW    = $clog2(TQ_DEPTH);

  typedef enum logic [4:0] {
    MODE_IDLE,
    MODE_GT,
    MODE_LT,
    MODE_BANG,
    MODE_SLASH,
    MODE_DOT,
    MODE_COLON,
    MODE_DOLLAR,
    MODE_VAR,
    MODE_VARCOLON,
    MODE_VARQ,
    MODE_INT,
    MODE_FRAC,
    MODE_NAME,
    MODE_NAMECOLON,
    MODE_NAMEQ,
    MODE_QUOTE,
    MODE_DROP
  } lex_mode_e;

  typedef enum logic [4:0] {
    KIND_EOF    = 5'd0,
    KIND_ERR    = 5'd1,
    KIND_EQ     = 5'd2,
    KIND_NE     = 5'd3,
    KIND_LT     = 5'd4,
    KIND_GT     = 5'd5,
    KIND_LE     = 5'd6,
    KIND_GE     = 5'd7,
    KIND_PLUS   = 5'd8,
    KIND_MINUS  = 5'd9,
    KIND_MUL    = 5'd10,
    KIND_UNION  = 5'd11,
    KIND_VAR    = 5'd12,
    KIND_LPAR   = 5'd13,
    KIND_RPAR   = 5'd14,
    KIND_SLASH  = 5'd15,
    KIND_DSLASH = 5'd16,
    KIND_LSQ    = 5'd17,
    KIND_RSQ    = 5'd18,
    KIND_COMMA  = 5'd19,
    KIND_DOT    = 5'd20,
    KIND_DDOT   = 5'd21,
    KIND_NUM    = 5'd22,
    KIND_AT     = 5'd23,
    KIND_QUOTED = 5'd24,
    KIND_DCOLON = 5'd25,
    KIND_NAME   = 5'd26
  } token_kind_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  cbeg;
    logic [POS_W-1:0]  cend;
    logic              last;
  } token_t;

  // Tokens produced by one accepted byte: cnt of 0, 1 or 2, t0 first
  typedef struct packed {
    logic [1:0] cnt;
    token_t     t0;
    token_t     t1;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/xpath_token_lexer_core.sv
// Channel   Handshake             Payload
// input     push / full           ch_i
// result    pop / empty           token_kind_o, token_pos_o, content_begin_o,
//                                 content_end_o, last_o
//
// One byte is taken per cycle while full is low; the lexer closes its tokens in the same cycle.
// A byte yields 0 to 2 tokens into a 4-entry token queue; results leave one per cycle while popped.
// full rises while fewer than two queue slots are free, so bytes that each
// cause two tokens are held back until the result port drains the queue.
// Reset clears lexer state and the queue; there is no clearing pass.
`default_nettype none

module xpath_token_lexer_core #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  ch_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [4:0]       token_kind_o,
  output logic [15:0]      token_pos_o,
  output logic [15:0]      content_begin_o,
  output logic [15:0]      content_end_o,
  output logic             last_o
);

  xtl_pkg::push_t  push_beat;
  xtl_pkg::token_t head;
  logic            accept;

  assign accept = push && !full;

  xtl_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ch_i     (ch_i),
    .accept_i (accept),
    .push_o   (push_beat)
  );

  xtl_tokq u_tokq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_beat),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  assign token_kind_o    = head.kind;
  assign token_pos_o     = head.pos;
  assign content_begin_o = head.cbeg;
  assign content_end_o   = head.cend;
  assign last_o          = head.last;

endmodule

`default_nettype wire

// File: rtl/xtl_front.sv
`default_nettype none

module xtl_front #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    ch_i,
  input  wire logic          accept_i,
  output xtl_pkg::push_t     push_o
);

  localparam logic [OFFSET_BITS-1:0] OffTop = '1;
  localparam logic [OFFSET_BITS-1:0] OffOne = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLpar   = 8'h28;
  localparam logic [7:0] ChRpar   = 8'h29;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChLsq    = 8'h5B;
  localparam logic [7:0] ChRsq    = 8'h5D;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChBar    = 8'h7C;

  function automatic xtl_pkg::token_t mk_tok(
    input logic [xtl_pkg::KIND_W-1:0] kind,
    input logic [OFFSET_BITS-1:0]     pos,
    input logic [OFFSET_BITS-1:0]     cb,
    input logic [OFFSET_BITS-1:0]     ce
  );
    xtl_pkg::token_t t;
    t.kind = kind;
    t.pos  = xtl_pkg::POS_W'(pos);
    t.cbeg = xtl_pkg::POS_W'(cb);
    t.cend = xtl_pkg::POS_W'(ce);
    t.last = 1'b0;
    return t;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == OffTop) ? v : v + OffOne;
  endfunction

  xtl_pkg::lex_mode_e       mode_q, mode_d;
  logic                     qsingle_q, qsingle_d;
  logic [OFFSET_BITS-1:0]   off_q, off_d;
  logic [OFFSET_BITS-1:0]   start_q, start_d;
  logic [OFFSET_BITS-1:0]   span_q, span_d;
  logic [OFFSET_BITS-1:0]   colon_q, colon_d;

  // Character classes of the current byte
  logic is_dig, is_ss, is_sy, is_nul, is_qend;
  xtl_pkg::lex_mode_e fail_mode;

  assign is_dig  = (ch_i >= 8'h30) && (ch_i <= 8'h39);
  assign is_ss   = ((ch_i >= 8'h61) && (ch_i <= 8'h7A)) || ((ch_i >= 8'h41) && (ch_i <= 8'h5A))
                   || (ch_i == ChUscore) || ch_i[7];
  assign is_sy   = is_ss || is_dig || (ch_i == ChMinus) || (ch_i == ChDot);
  assign is_nul  = (ch_i == ChNul);
  assign is_qend = (ch_i == (qsingle_q ? ChSquote : ChDquote));
  assign fail_mode = is_nul ? xtl_pkg::MODE_IDLE : xtl_pkg::MODE_DROP;

  // Tokens: a is the token the byte closes, b a colon follow-up, c what the byte starts
  logic            av, bv, cv, do_begin, qend;
  xtl_pkg::token_t a_tok, b_tok, c_tok;
  logic [OFFSET_BITS-1:0] p;

  assign p = off_q;

  // Close or extend the pending token
  always_comb begin
    av        = 1'b0;
    bv        = 1'b0;
    cv        = 1'b0;
    a_tok     = '0;
    b_tok     = '0;
    c_tok     = '0;
    do_begin  = 1'b0;
    qend      = 1'b0;
    mode_d    = mode_q;
    start_d   = start_q;
    span_d    = span_q;
    colon_d   = colon_q;
    qsingle_d = qsingle_q;

    case (mode_q)
      xtl_pkg::MODE_GT, xtl_pkg::MODE_LT: begin
        av = 1'b1;
        if (ch_i == ChEq) begin
          a_tok  = mk_tok((mode_q == xtl_pkg::MODE_GT) ? xtl_pkg::KIND_GE : xtl_pkg::KIND_LE,
                          start_q, '0, '0);
          mode_d = xtl_pkg::MODE_IDLE;
        end else begin
          a_tok    = mk_tok((mode_q == xtl_pkg::MODE_GT) ? xtl_pkg::KIND_GT : xtl_pkg::KIND_LT,
                            start_q, '0, '0);
          do_begin = 1'b1;
        end
      end
      xtl_pkg::MODE_SLASH: begin
        av = 1'b1;
        if (ch_i == ChSlash) begin
          a_tok  = mk_tok(xtl_pkg::KIND_DSLASH, start_q, '0, '0);
          mode_d = xtl_pkg::MODE_IDLE;
        end else begin
          a_tok    = mk_tok(xtl_pkg::KIND_SLASH, start_q, '0, '0);
          do_begin = 1'b1;
        end
      end
      xtl_pkg::MODE_BANG: begin
        av = 1'b1;
        if (ch_i == ChEq) begin
          a_tok  = mk_tok(xtl_pkg::KIND_NE, start_q, '0, '0);
          mode_d = xtl_pkg::MODE_IDLE;
        end else begin
          a_tok  = mk_tok(xtl_pkg::KIND_ERR, start_q, '0, '0);
          mode_d = fail_mode;
          qend   = is_nul;
        end
      end
      xtl_pkg::MODE_COLON: begin
        av = 1'b1;
        if (ch_i == ChColon) begin
          a_tok  = mk_tok(xtl_pkg::KIND_DCOLON, start_q, '0, '0);
          mode_d = xtl_pkg::MODE_IDLE;
        end else begin
          a_tok  = mk_tok(xtl_pkg::KIND_ERR, start_q, '0, '0);
          mode_d = fail_mode;
          qend   = is_nul;
        end
      end
      xtl_pkg::MODE_DOT: begin
        if (ch_i == ChDot) begin
          av     = 1'b1;
          a_tok  = mk_tok(xtl_pkg::KIND_DDOT, start_q, '0, '0);
          mode_d = xtl_pkg::MODE_IDLE;
        end else if (is_dig) begin
          span_d = start_q;
          mode_d = xtl_pkg::MODE_FRAC;
        end else begin
          av       = 1'b1;
          a_tok    = mk_tok(xtl_pkg::KIND_DOT, start_q, '0, '0);
          do_begin = 1'b1;
        end
      end
      xtl_pkg::MODE_DOLLAR: begin
        if (is_ss) begin
          span_d = p;
          mode_d = xtl_pkg::MODE_VAR;
        end else begin
          av     = 1'b1;
          a_tok  = mk_tok(xtl_pkg::KIND_ERR, start_q, '0, '0);
          mode_d = fail_mode;
          qend   = is_nul;
        end
      end
      xtl_pkg::MODE_VAR, xtl_pkg::MODE_NAME: begin
        if (is_sy) begin
          mode_d = mode_q;
        end else if (ch_i == ChColon) begin
          colon_d = p;
          mode_d  = (mode_q == xtl_pkg::MODE_VAR) ? xtl_pkg::MODE_VARCOLON
                                                  : xtl_pkg::MODE_NAMECOLON;
        end else begin
          av       = 1'b1;
          a_tok    = (mode_q == xtl_pkg::MODE_VAR)
                     ? mk_tok(xtl_pkg::KIND_VAR, start_q, span_q, p)
                     : mk_tok(xtl_pkg::KIND_NAME, span_q, span_q, p);
          do_begin = 1'b1;
        end
      end
      xtl_pkg::MODE_VARCOLON, xtl_pkg::MODE_NAMECOLON: begin
        if ((mode_q == xtl_pkg::MODE_NAMECOLON) && (ch_i == ChStar)) begin
          av     = 1'b1;
          a_tok  = mk_tok(xtl_pkg::KIND_NAME, span_q, span_q, sat_inc(p));
          mode_d = xtl_pkg::MODE_IDLE;
        end else if (is_sy) begin
          mode_d = (mode_q == xtl_pkg::MODE_VARCOLON) ? xtl_pkg::MODE_VARQ
                                                      : xtl_pkg::MODE_NAMEQ;
        end else begin
          // Close the name at the colon, then the colon needs a second colon
          av    = 1'b1;
          a_tok = (mode_q == xtl_pkg::MODE_VARCOLON)
                  ? mk_tok(xtl_pkg::KIND_VAR, start_q, span_q, colon_q)
                  : mk_tok(xtl_pkg::KIND_NAME, span_q, span_q, colon_q);
          bv    = 1'b1;
          if (ch_i == ChColon) begin
            b_tok  = mk_tok(xtl_pkg::KIND_DCOLON, colon_q, '0, '0);
            mode_d = xtl_pkg::MODE_IDLE;
          end else begin
            b_tok  = mk_tok(xtl_pkg::KIND_ERR, colon_q, '0, '0);
            mode_d = fail_mode;
            qend   = is_nul;
          end
        end
      end
      xtl_pkg::MODE_VARQ, xtl_pkg::MODE_NAMEQ: begin
        if (!is_sy) begin
          av       = 1'b1;
          a_tok    = (mode_q == xtl_pkg::MODE_VARQ)
                     ? mk_tok(xtl_pkg::KIND_VAR, start_q, span_q, p)
                     : mk_tok(xtl_pkg::KIND_NAME, span_q, span_q, p);
          do_begin = 1'b1;
        end
      end
      xtl_pkg::MODE_INT, xtl_pkg::MODE_FRAC: begin
        if (is_dig) begin
          mode_d = mode_q;
        end else if ((mode_q == xtl_pkg::MODE_INT) && (ch_i == ChDot)) begin
          mode_d = xtl_pkg::MODE_FRAC;
        end else begin
          av       = 1'b1;
          a_tok    = mk_tok(xtl_pkg::KIND_NUM, span_q, span_q, p);
          do_begin = 1'b1;
        end
      end
      xtl_pkg::MODE_QUOTE: begin
        if (is_qend) begin
          av     = 1'b1;
          a_tok  = mk_tok(xtl_pkg::KIND_QUOTED, start_q, span_q, p);
          mode_d = xtl_pkg::MODE_IDLE;
        end else if (is_nul) begin
          av     = 1'b1;
          a_tok  = mk_tok(xtl_pkg::KIND_ERR, start_q, '0, '0);
          mode_d = xtl_pkg::MODE_IDLE;
          qend   = 1'b1;
        end
      end
      xtl_pkg::MODE_DROP: begin
        if (is_nul) begin
          mode_d = xtl_pkg::MODE_IDLE;
          qend   = 1'b1;
        end
      end
      default: begin
        do_begin = 1'b1;
      end
    endcase

    // Start a new token on this byte
    if (do_begin) begin
      mode_d  = xtl_pkg::MODE_IDLE;
      start_d = p;
      case (ch_i)
        ChNul: begin
          cv    = 1'b1;
          c_tok = mk_tok(xtl_pkg::KIND_EOF, p, '0, '0);
          qend  = 1'b1;
        end
        ChSpace, ChTab, ChLf, ChCr: begin
          mode_d = xtl_pkg::MODE_IDLE;
        end
        ChGt:     mode_d = xtl_pkg::MODE_GT;
        ChLt:     mode_d = xtl_pkg::MODE_LT;
        ChBang:   mode_d = xtl_pkg::MODE_BANG;
        ChSlash:  mode_d = xtl_pkg::MODE_SLASH;
        ChDot:    mode_d = xtl_pkg::MODE_DOT;
        ChColon:  mode_d = xtl_pkg::MODE_COLON;
        ChDollar: mode_d = xtl_pkg::MODE_DOLLAR;
        ChEq:     begin cv = 1'b1; c_tok = mk_tok(xtl_pkg::KIND_EQ, p, '0, '0); end
        ChPlus:   begin cv = 1'b1; c_tok = mk_tok(xtl_pkg::KIND_PLUS, p, '0, '0); end
        ChMinus:  begin cv = 1'b1; c_tok = mk_tok(xtl_pkg::KIND_MINUS, p, '0, '0); end
        ChStar:   begin cv = 1'b1; c_tok = mk_tok(xtl_pkg::KIND_MUL, p, '0, '0); end
        ChBar:    begin cv = 1'b1; c_tok = mk_tok(xtl_pkg::KIND_UNION, p, '0, '0); end
        ChLpar:   begin cv = 1'b1; c_tok = mk_tok(xtl_pkg::KIND_LPAR, p, '0, '0); end
        ChRpar:   begin cv = 1'b1; c_tok = mk_tok(xtl_pkg::KIND_RPAR, p, '0, '0); end
        ChLsq:    begin cv = 1'b1; c_tok = mk_tok(xtl_pkg::KIND_LSQ, p, '0, '0); end
        ChRsq:    begin cv = 1'b1; c_tok = mk_tok(xtl_pkg::KIND_RSQ, p, '0, '0); end
        ChComma:  begin cv = 1'b1; c_tok = mk_tok(xtl_pkg::KIND_COMMA, p, '0, '0); end
        ChAt:     begin cv = 1'b1; c_tok = mk_tok(xtl_pkg::KIND_AT, p, '0, '0); end
        ChDquote, ChSquote: begin
          qsingle_d = (ch_i == ChSquote);
          span_d    = sat_inc(p);
          mode_d    = xtl_pkg::MODE_QUOTE;
        end
        default: begin
          if (is_dig) begin
            span_d = p;
            mode_d = xtl_pkg::MODE_INT;
          end else if (is_ss) begin
            span_d = p;
            mode_d = xtl_pkg::MODE_NAME;
          end else begin
            cv     = 1'b1;
            c_tok  = mk_tok(xtl_pkg::KIND_ERR, p, '0, '0);
            mode_d = xtl_pkg::MODE_DROP;
          end
        end
      endcase
    end

    off_d = qend ? '0 : sat_inc(p);
  end

  // Pack the beat for the token queue; only an accepted byte pushes
  logic [1:0] cnt;
  assign cnt = {1'b0, av} + {1'b0, bv} + {1'b0, cv};

  always_comb begin
    push_o.cnt     = accept_i ? cnt : 2'd0;
    push_o.t0      = av ? a_tok : c_tok;
    push_o.t1      = bv ? b_tok : c_tok;
    push_o.t0.last = (cnt == 2'd1);
    push_o.t1.last = 1'b1;
  end

  // Advance lexer state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= xtl_pkg::MODE_IDLE;
      qsingle_q <= 1'b0;
      off_q     <= '0;
      start_q   <= '0;
      span_q    <= '0;
      colon_q   <= '0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      qsingle_q <= qsingle_d;
      off_q     <= off_d;
      start_q   <= start_d;
      span_q    <= span_d;
      colon_q   <= colon_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/xtl_tokq.sv
`default_nettype none

module xtl_tokq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire xtl_pkg::push_t  push_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output logic                 empty_o,
  output xtl_pkg::token_t      head_o
);

  localparam logic [xtl_pkg::TQ_AW-1:0] PtrOne = {{(xtl_pkg::TQ_AW-1){1'b0}}, 1'b1};

  xtl_pkg::token_t             mem_q [xtl_pkg::TQ_DEPTH];
  logic [xtl_pkg::TQ_AW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [xtl_pkg::TQ_AW:0]     count_q, count_d;
  logic                        pop;

  assign pop     = pop_i && (count_q != '0);
  assign empty_o = (count_q == '0);
  // Leave room for the two tokens one byte may produce
  assign full_o  = (count_q > (xtl_pkg::TQ_AW + 1)'(xtl_pkg::TQ_DEPTH - 2));
  assign head_o  = mem_q[rp_q];

  // Move pointers and fill level
  always_comb begin
    wp_d    = wp_q + xtl_pkg::TQ_AW'(push_i.cnt);
    rp_d    = pop ? rp_q + PtrOne : rp_q;
    count_d = count_q + (xtl_pkg::TQ_AW + 1)'(push_i.cnt)
              - (xtl_pkg::TQ_AW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  // Store up to two tokens per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wp_q] <= push_i.t0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wp_q + PtrOne] <= push_i.t1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/xtl_checker.sv
`default_nettype none

`include "xpath_token_lexer_core_macros.svh"

module xtl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [4:0]  token_kind_o,
  input wire logic [15:0] content_begin_o,
  input wire logic [15:0] content_end_o,
  input wire logic        last_o
);

  // Back-pressure only comes from tokens waiting
  `XTL_ASSERT_IMP(a_full_not_empty, full, !empty)

  // No kind beyond name leaves the block
  `XTL_ASSERT_IMP(a_kind_range, !empty, token_kind_o <= xtl_pkg::KIND_NAME)

  // End of query closes its byte and carries no content span
  `XTL_ASSERT_IMP(a_eof_shape, !empty && (token_kind_o == xtl_pkg::KIND_EOF),
                  last_o && (content_begin_o == 16'd0) && (content_end_o == 16'd0))

  // Hold a waiting token until popped
  `XTL_ASSERT_NXT(a_hold_beat, !empty && !pop,
                  !empty && $stable(token_kind_o) && $stable(last_o))

endmodule

bind xpath_token_lexer_core xtl_checker u_xtl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .token_kind_o    (token_kind_o),
  .content_begin_o (content_begin_o),
  .content_end_o   (content_end_o),
  .last_o          (last_o)
);

`default_nettype wire
